/* design/acia_pkg.sv */
// Package with the opcodes, register bit positions and constants of the serial ACIA register model.
package acia_pkg;

  localparam int unsigned CNT_W = 5;
  localparam int unsigned HOST_DEPTH_DEF = 1;

  typedef enum logic [2:0] {
    OP_BUS_READ  = 3'd0,
    OP_BUS_WRITE = 3'd1,
    OP_HOST_PUT  = 3'd2,
    OP_HOST_TAKE = 3'd3,
    OP_UPDATE    = 3'd4
  } op_e;

  localparam logic       SEL_CTRL = 1'b0;

  localparam int unsigned ST_RX_FULL_BIT  = 0;
  localparam int unsigned ST_TX_EMPTY_BIT = 1;
  localparam int unsigned ST_IRQ_BIT      = 7;

  localparam logic [7:0] ST_AFTER_RESET  = 8'h02;
  localparam logic [7:0] CR_RX_IRQ_EN    = 8'h80;
  localparam logic [7:0] CR_TX_IRQ_MASK  = 8'h60;
  localparam logic [7:0] CR_TX_IRQ_VAL   = 8'h20;
  localparam logic [7:0] CR_MASTER_RESET = 8'h03;
  localparam logic [7:0] EMPTY_TAKE      = 8'hFF;

endpackage

/* design/serial_acia_register_model_core.sv */
// Top level of the serial ACIA register model with its host-side byte stacks.
// The block takes one beat per clock cycle and answers each beat with exactly one result beat,
// shown in the following cycle. All state (control, status, both data registers and the two last-in
// first-out host stacks of HOST_DEPTH entries) is updated at the edge that accepts the beat,
// and the result is held in an output register. A new beat is taken whenever that register is
// empty or being emptied in the same cycle, so throughput is one beat per cycle unless the
// result side stalls. No clearing pass is needed after reset.
module serial_acia_register_model_core
  import acia_pkg::*;
#(
  parameter int unsigned HOST_DEPTH = HOST_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       opcode_i,
  input  logic             reg_select_i,
  input  logic [7:0]       data_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       read_data_o,
  output logic [7:0]       host_data_o,
  output logic             irq_o,
  output logic [CNT_W-1:0] host_bytes_waiting_o,
  output logic             host_full_o
);

  localparam int unsigned IdxW = (HOST_DEPTH > 1) ? $clog2(HOST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(HOST_DEPTH);

  logic [7:0]       ctrl_q, ctrl_d;
  logic [7:0]       status_q, status_d;
  logic [7:0]       rx_data_q, rx_data_d;
  logic [7:0]       tx_data_q, tx_data_d;
  logic [CNT_W-1:0] in_cnt_q, in_cnt_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [7:0]       in_stack_q [HOST_DEPTH];
  logic [7:0]       out_stack_q [HOST_DEPTH];

  logic             out_valid_q;
  logic [7:0]       read_data_q, read_data_d;
  logic [7:0]       host_data_q, host_data_d;
  logic             irq_q;
  logic [CNT_W-1:0] waiting_q;
  logic             full_q;

  logic             in_fire;
  logic             in_push, out_push;
  logic [CNT_W-1:0] in_cnt_dec, out_cnt_dec;
  logic [7:0]       in_top, out_top;
  logic             rx_irq_on, tx_irq_on;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign in_cnt_dec  = in_cnt_q - CNT_W'(1);
  assign out_cnt_dec = out_cnt_q - CNT_W'(1);
  assign in_top      = in_stack_q[in_cnt_dec[IdxW-1:0]];
  assign out_top     = out_stack_q[out_cnt_dec[IdxW-1:0]];
  assign rx_irq_on   = (ctrl_q & CR_RX_IRQ_EN) != 8'h00;
  assign tx_irq_on   = (ctrl_q & CR_TX_IRQ_MASK) == CR_TX_IRQ_VAL;

  always_comb begin
    ctrl_d      = ctrl_q;
    status_d    = status_q;
    rx_data_d   = rx_data_q;
    tx_data_d   = tx_data_q;
    in_cnt_d    = in_cnt_q;
    out_cnt_d   = out_cnt_q;
    read_data_d = 8'h00;
    host_data_d = 8'h00;
    in_push     = 1'b0;
    out_push    = 1'b0;
    unique case (opcode_i)
      OP_BUS_READ: begin
        if (reg_select_i == SEL_CTRL) begin
          read_data_d = status_q;
        end else begin
          status_d[ST_RX_FULL_BIT] = 1'b0;
          if (rx_irq_on) begin
            status_d[ST_IRQ_BIT] = 1'b0;
          end
          read_data_d = rx_data_q;
        end
      end
      OP_BUS_WRITE: begin
        if (reg_select_i == SEL_CTRL) begin
          ctrl_d = data_in_i;
          if ((data_in_i & CR_MASTER_RESET) == CR_MASTER_RESET) begin
            status_d  = ST_AFTER_RESET;
            rx_data_d = 8'h00;
            tx_data_d = 8'h00;
          end
        end else begin
          tx_data_d                 = data_in_i;
          status_d[ST_TX_EMPTY_BIT] = 1'b0;
          if (tx_irq_on) begin
            status_d[ST_IRQ_BIT] = 1'b0;
          end
        end
      end
      OP_HOST_PUT: begin
        if (in_cnt_q < DepthC) begin
          in_push  = 1'b1;
          in_cnt_d = in_cnt_q + CNT_W'(1);
        end
      end
      OP_HOST_TAKE: begin
        if (out_cnt_q != '0) begin
          out_cnt_d   = out_cnt_dec;
          host_data_d = out_top;
        end else begin
          host_data_d = EMPTY_TAKE;
        end
      end
      OP_UPDATE: begin
        if (!status_q[ST_RX_FULL_BIT] && in_cnt_q != '0) begin
          in_cnt_d                 = in_cnt_dec;
          rx_data_d                = in_top;
          status_d[ST_RX_FULL_BIT] = 1'b1;
          if (rx_irq_on) begin
            status_d[ST_IRQ_BIT] = 1'b1;
          end
        end
        if (!status_q[ST_TX_EMPTY_BIT] && out_cnt_q < DepthC) begin
          out_push                  = 1'b1;
          out_cnt_d                 = out_cnt_q + CNT_W'(1);
          status_d[ST_TX_EMPTY_BIT] = 1'b1;
          if (tx_irq_on) begin
            status_d[ST_IRQ_BIT] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= 8'h00;
      status_q    <= ST_AFTER_RESET;
      rx_data_q   <= 8'h00;
      tx_data_q   <= 8'h00;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        ctrl_q    <= ctrl_d;
        status_q  <= status_d;
        rx_data_q <= rx_data_d;
        tx_data_q <= tx_data_d;
        in_cnt_q  <= in_cnt_d;
        out_cnt_q <= out_cnt_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_push) begin
      in_stack_q[in_cnt_q[IdxW-1:0]] <= data_in_i;
    end
    if (in_fire && out_push) begin
      out_stack_q[out_cnt_q[IdxW-1:0]] <= tx_data_q;
    end
    if (in_fire) begin
      read_data_q <= read_data_d;
      host_data_q <= host_data_d;
      irq_q       <= status_d[ST_IRQ_BIT];
      waiting_q   <= out_cnt_d;
      full_q      <= in_cnt_d >= DepthC;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign read_data_o          = read_data_q;
  assign host_data_o          = host_data_q;
  assign irq_o                = irq_q;
  assign host_bytes_waiting_o = waiting_q;
  assign host_full_o          = full_q;

  // The stack fill counts never pass the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_cnt_q <= DepthC) && (out_cnt_q <= DepthC))
    else $error("host stack count beyond depth");

  // Only the receive full, transmit empty and interrupt bits of the status register are used.
  assert property (@(posedge clk_i) disable iff (!rst_ni) status_q[6:2] == 5'b00000)
    else $error("unused status bit set");

  // A take from a non-empty outbound stack removes exactly one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode_i == OP_HOST_TAKE && out_cnt_q != '0)
    |=> out_cnt_q == $past(out_cnt_q) - CNT_W'(1))
    else $error("host take did not pop one byte");

  // A result beat reports the outbound count left by the beat that produced it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_valid_o && host_bytes_waiting_o == out_cnt_q))
    else $error("result count differs from stack state");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the serial ACIA register model core, with its own register predictor.
`timescale 1ns / 1ps

module testbench;
  import acia_pkg::*;

  localparam int unsigned STACK_DEPTH = HOST_DEPTH_DEF;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
  localparam logic SEL_DATA = ~SEL_CTRL;
  localparam int unsigned RANDOM_BEATS = 1000;
  localparam int unsigned HOLD_OFF_START = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 48;
  localparam int unsigned DRAIN_LIMIT = 2000;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SENDER_GAPS,
    PH_RECEIVER_STALLS,
    PH_BOTH
  } idle_phase_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic       reg_select;
    logic [7:0] data_in;
  } bus_beat_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [7:0]       host_data;
    logic             irq;
    logic [CNT_W-1:0] host_bytes_waiting;
    logic             host_full;
  } acia_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [2:0] opcode_i = '0;
  logic reg_select_i = 1'b0;
  logic [7:0] data_in_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [7:0] read_data_o;
  logic [7:0] host_data_o;
  logic irq_o;
  logic [CNT_W-1:0] host_bytes_waiting_o;
  logic host_full_o;

  bus_beat_t bus_beats[$];
  acia_result_t due_results[$];
  int accepted_cnt = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int errs = 0;
  idle_phase_e idle_phase;

  logic [7:0] ctrl_q;
  logic [7:0] stat_q;
  logic [7:0] rx_data_q;
  logic [7:0] tx_data_q;
  logic [7:0] inbound_q[STACK_DEPTH];
  logic [7:0] outbound_q[STACK_DEPTH];
  int inbound_cnt;
  int outbound_cnt;

  serial_acia_register_model_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .reg_select_i        (reg_select_i),
    .data_in_i           (data_in_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .read_data_o         (read_data_o),
    .host_data_o         (host_data_o),
    .irq_o               (irq_o),
    .host_bytes_waiting_o(host_bytes_waiting_o),
    .host_full_o         (host_full_o)
  );

  always #6 clk_i = ~clk_i;

  assign idle_phase = idle_phase_e'(accepted_cnt[8:7]);

  function automatic int unsigned sender_gap_pct(idle_phase_e ph);
    case (ph)
      PH_SENDER_GAPS: return 58;
      PH_BOTH: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(idle_phase_e ph);
    case (ph)
      PH_RECEIVER_STALLS: return 58;
      PH_BOTH: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic void clear_registers();
    stat_q = ST_AFTER_RESET;
    rx_data_q = '0;
    tx_data_q = '0;
  endfunction

  function automatic acia_result_t acia_step(logic [2:0] op, logic sel, logic [7:0] byte_in);
    acia_result_t res;
    logic rx_irq_en;
    logic tx_irq_en;
    res = '0;
    rx_irq_en = (ctrl_q & CR_RX_IRQ_EN) != '0;
    tx_irq_en = (ctrl_q & CR_TX_IRQ_MASK) == CR_TX_IRQ_VAL;
    case (op)
      OP_BUS_READ: begin
        if (sel == SEL_CTRL) begin
          res.read_data = stat_q;
        end else begin
          stat_q[ST_RX_FULL_BIT] = 1'b0;
          if (rx_irq_en) stat_q[ST_IRQ_BIT] = 1'b0;
          res.read_data = rx_data_q;
        end
      end
      OP_BUS_WRITE: begin
        if (sel == SEL_CTRL) begin
          ctrl_q = byte_in;
          if ((byte_in & CR_MASTER_RESET) == CR_MASTER_RESET) clear_registers();
        end else begin
          tx_data_q = byte_in;
          stat_q[ST_TX_EMPTY_BIT] = 1'b0;
          if (tx_irq_en) stat_q[ST_IRQ_BIT] = 1'b0;
        end
      end
      OP_HOST_PUT: begin
        if (inbound_cnt < STACK_DEPTH) begin
          inbound_q[inbound_cnt] = byte_in;
          inbound_cnt++;
        end
      end
      OP_HOST_TAKE: begin
        if (outbound_cnt > 0) begin
          outbound_cnt--;
          res.host_data = outbound_q[outbound_cnt];
        end else begin
          res.host_data = EMPTY_TAKE;
        end
      end
      OP_UPDATE: begin
        if (!stat_q[ST_RX_FULL_BIT] && inbound_cnt > 0) begin
          inbound_cnt--;
          rx_data_q = inbound_q[inbound_cnt];
          stat_q[ST_RX_FULL_BIT] = 1'b1;
          if (rx_irq_en) stat_q[ST_IRQ_BIT] = 1'b1;
        end
        if (!stat_q[ST_TX_EMPTY_BIT] && outbound_cnt < STACK_DEPTH) begin
          outbound_q[outbound_cnt] = tx_data_q;
          outbound_cnt++;
          stat_q[ST_TX_EMPTY_BIT] = 1'b1;
          if (tx_irq_en) stat_q[ST_IRQ_BIT] = 1'b1;
        end
      end
      default: ;
    endcase
    res.irq = stat_q[ST_IRQ_BIT];
    res.host_bytes_waiting = outbound_cnt[CNT_W-1:0];
    res.host_full = inbound_cnt >= STACK_DEPTH;
    return res;
  endfunction

  function automatic void queue_beat(logic [2:0] op, logic sel, logic [7:0] byte_in);
    bus_beat_t b;
    b.opcode = op;
    b.reg_select = sel;
    b.data_in = byte_in;
    bus_beats.push_back(b);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_beat_t nxt;
    logic offering;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i <= '0;
      reg_select_i <= 1'b0;
      data_in_i <= '0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(acia_step(opcode_i, reg_select_i, data_in_i));
        accepted_cnt <= accepted_cnt + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (bus_beats.size() != 0 &&
            $urandom_range(0, 99) >= sender_gap_pct(idle_phase)) begin
          nxt = bus_beats.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= nxt.opcode;
          reg_select_i <= nxt.reg_select;
          data_in_i <= nxt.data_in;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The long hold-off lets the output register fill so that the input side has to stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_OFF_START) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    acia_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          errs++;
        end else begin
          want = due_results.pop_front();
          if (read_data_o !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, read_data_o);
            errs++;
          end
          if (host_data_o !== want.host_data) begin
            $error("host_data: expected %0h, actual %0h", want.host_data, host_data_o);
            errs++;
          end
          if (irq_o !== want.irq) begin
            $error("irq: expected %0h, actual %0h", want.irq, irq_o);
            errs++;
          end
          if (host_bytes_waiting_o !== want.host_bytes_waiting) begin
            $error("host_bytes_waiting: expected %0h, actual %0h",
                   want.host_bytes_waiting, host_bytes_waiting_o);
            errs++;
          end
          if (host_full_o !== want.host_full) begin
            $error("host_full: expected %0h, actual %0h", want.host_full, host_full_o);
            errs++;
          end
        end
      end
      out_stall_i <= (hold_left > 1) ||
                     ($urandom_range(0, 99) < receiver_stall_pct(idle_phase));
    end
  end

  initial begin
    int unsigned pick;
    logic [2:0] op;
    logic sel;
    logic [7:0] dat;
    int n;
    ctrl_q = '0;
    clear_registers();
    inbound_cnt = 0;
    outbound_cnt = 0;
    foreach (inbound_q[i]) inbound_q[i] = '0;
    foreach (outbound_q[i]) outbound_q[i] = '0;

    queue_beat(OP_BUS_READ, SEL_CTRL, 8'h00);
    queue_beat(OP_HOST_TAKE, SEL_CTRL, 8'h00);
    queue_beat(OP_BUS_WRITE, SEL_CTRL, 8'hA0);
    queue_beat(OP_HOST_PUT, SEL_DATA, 8'hFF);
    queue_beat(OP_HOST_PUT, SEL_CTRL, 8'h55);
    queue_beat(OP_BUS_WRITE, SEL_DATA, 8'hAA);
    queue_beat(OP_UPDATE, SEL_CTRL, 8'h00);
    queue_beat(OP_BUS_READ, SEL_CTRL, 8'hFF);
    queue_beat(OP_BUS_READ, SEL_DATA, 8'h00);
    queue_beat(OP_HOST_TAKE, SEL_DATA, 8'hFF);
    queue_beat(OP_HOST_TAKE, SEL_CTRL, 8'h00);
    queue_beat(OP_BUS_WRITE, SEL_DATA, 8'h01);
    queue_beat(OP_UPDATE, SEL_DATA, 8'hFF);
    queue_beat(OP_BUS_WRITE, SEL_DATA, 8'h02);
    queue_beat(OP_UPDATE, SEL_CTRL, 8'h00);
    queue_beat(OP_BUS_READ, SEL_CTRL, 8'h00);
    queue_beat(OP_HOST_PUT, SEL_CTRL, 8'h00);
    queue_beat(OP_BUS_WRITE, SEL_CTRL, 8'hFF);
    queue_beat(OP_BUS_READ, SEL_CTRL, 8'h00);
    queue_beat(OP_BUS_READ, SEL_DATA, 8'h00);
    for (int u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++) begin
      queue_beat(u[2:0], SEL_DATA, 8'hFF);
    end
    queue_beat(OP_BUS_WRITE, SEL_CTRL, 8'h00);
    queue_beat(OP_UPDATE, SEL_CTRL, 8'h00);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      pick = $urandom_range(0, 99);
      sel = 1'($urandom_range(0, 1));
      dat = 8'($urandom_range(0, 255));
      if (pick < 14) op = OP_BUS_READ;
      else if (pick < 34) op = OP_BUS_WRITE;
      else if (pick < 54) op = OP_HOST_PUT;
      else if (pick < 70) op = OP_HOST_TAKE;
      else if (pick < 96) op = OP_UPDATE;
      else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      // Master resets are kept rare so that the flags build up between them.
      if (op == OP_BUS_WRITE && sel == SEL_CTRL && $urandom_range(0, 2) != 0) dat[1] = 1'b0;
      queue_beat(op, sel, dat);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bus_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    n = 0;
    while (due_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      errs++;
    end
    if (errs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* serial_acia_register_model_core.f */
design/acia_pkg.sv
design/serial_acia_register_model_core.sv
dv/testbench.sv
